FILE: sv/mis_mde_pkg.sv
package mis_mde_pkg;

  localparam int unsigned MaxNodesDefault = 256;

  localparam logic [15:0] XOne  = 16'd32768;
  localparam logic [15:0] XHalf = 16'd16384;

  localparam logic [31:0] LearningRateReset   = 32'd1288490;
  localparam logic [15:0] MomentumFactorReset = 16'd58982;
  localparam logic [11:0] EdgePenaltyReset    = 12'd350;
  localparam logic [7:0]  NonedgeRewardReset  = 8'd7;
  localparam logic [8:0]  NodeCountReset      = 9'd256;

  typedef enum logic [2:0] {
    OP_ADD_EDGE = 3'd0,
    OP_WRITE_X  = 3'd1,
    OP_ITERATE  = 3'd2,
    OP_CHECK    = 3'd3,
    OP_READ_X   = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    REG_LEARNING_RATE   = 3'd0,
    REG_MOMENTUM_FACTOR = 3'd1,
    REG_EDGE_PENALTY    = 3'd2,
    REG_NONEDGE_REWARD  = 3'd3,
    REG_NODE_COUNT      = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_RA,
    ST_EDGE_WA,
    ST_EDGE_RB,
    ST_EDGE_WB,
    ST_WRX,
    ST_RDX,
    ST_RDX_OUT,
    ST_NOP,
    ST_SCAN,
    ST_DRAIN,
    ST_CHECK_END,
    ST_NODE_A,
    ST_NODE_B,
    ST_NODE_C,
    ST_NODE_D,
    ST_NODE_E,
    ST_NODE_F
  } state_e;

  typedef struct packed {
    logic clr;
    logic cnt_clr;
    logic cnt_inc;
    logic latch;
    logic scan_rd;
    logic edge_rd_a;
    logic edge_wr_a;
    logic edge_rd_b;
    logic edge_wr_b;
    logic wrx;
    logic rdx;
    logic mul1;
    logic grad;
    logic mul2;
    logic vel;
    logic upd;
    logic result;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic clr_last;
    logic is_iter;
  } dp_status_t;

endpackage

FILE: sv/mis_mde_ctrl.sv
module mis_mde_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  logic [2:0]             opcode_i,
  input  mis_mde_pkg::dp_status_t status_i,
  output mis_mde_pkg::dp_cmd_t    cmd_o,
  output logic                   busy
);

  mis_mde_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mis_mde_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != mis_mde_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mis_mde_pkg::ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = mis_mde_pkg::ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      mis_mde_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.latch   = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          unique case (opcode_i)
            mis_mde_pkg::OP_ADD_EDGE: state_d = mis_mde_pkg::ST_EDGE_RA;
            mis_mde_pkg::OP_WRITE_X:  state_d = mis_mde_pkg::ST_WRX;
            mis_mde_pkg::OP_ITERATE:  state_d = mis_mde_pkg::ST_SCAN;
            mis_mde_pkg::OP_CHECK:    state_d = mis_mde_pkg::ST_SCAN;
            mis_mde_pkg::OP_READ_X:   state_d = mis_mde_pkg::ST_RDX;
            default:                  state_d = mis_mde_pkg::ST_NOP;
          endcase
        end
      end
      mis_mde_pkg::ST_EDGE_RA: begin
        cmd_o.edge_rd_a = 1'b1;
        state_d         = mis_mde_pkg::ST_EDGE_WA;
      end
      mis_mde_pkg::ST_EDGE_WA: begin
        cmd_o.edge_wr_a = 1'b1;
        state_d         = mis_mde_pkg::ST_EDGE_RB;
      end
      mis_mde_pkg::ST_EDGE_RB: begin
        cmd_o.edge_rd_b = 1'b1;
        state_d         = mis_mde_pkg::ST_EDGE_WB;
      end
      mis_mde_pkg::ST_EDGE_WB: begin
        cmd_o.edge_wr_b = 1'b1;
        cmd_o.result    = 1'b1;
        state_d         = mis_mde_pkg::ST_IDLE;
      end
      mis_mde_pkg::ST_WRX: begin
        cmd_o.wrx    = 1'b1;
        cmd_o.result = 1'b1;
        state_d      = mis_mde_pkg::ST_IDLE;
      end
      mis_mde_pkg::ST_RDX: begin
        cmd_o.rdx = 1'b1;
        state_d   = mis_mde_pkg::ST_RDX_OUT;
      end
      mis_mde_pkg::ST_RDX_OUT: begin
        cmd_o.result = 1'b1;
        state_d      = mis_mde_pkg::ST_IDLE;
      end
      mis_mde_pkg::ST_NOP: begin
        cmd_o.result = 1'b1;
        state_d      = mis_mde_pkg::ST_IDLE;
      end
      mis_mde_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (status_i.cnt_last) begin
          state_d = mis_mde_pkg::ST_DRAIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      mis_mde_pkg::ST_DRAIN: begin
        cmd_o.cnt_clr = 1'b1;
        if (status_i.is_iter) begin
          state_d = mis_mde_pkg::ST_NODE_A;
        end else begin
          state_d = mis_mde_pkg::ST_CHECK_END;
        end
      end
      mis_mde_pkg::ST_CHECK_END: begin
        cmd_o.result = 1'b1;
        state_d      = mis_mde_pkg::ST_IDLE;
      end
      mis_mde_pkg::ST_NODE_A: begin
        state_d = mis_mde_pkg::ST_NODE_B;
      end
      mis_mde_pkg::ST_NODE_B: begin
        cmd_o.mul1 = 1'b1;
        state_d    = mis_mde_pkg::ST_NODE_C;
      end
      mis_mde_pkg::ST_NODE_C: begin
        cmd_o.grad = 1'b1;
        state_d    = mis_mde_pkg::ST_NODE_D;
      end
      mis_mde_pkg::ST_NODE_D: begin
        cmd_o.mul2 = 1'b1;
        state_d    = mis_mde_pkg::ST_NODE_E;
      end
      mis_mde_pkg::ST_NODE_E: begin
        cmd_o.vel = 1'b1;
        state_d   = mis_mde_pkg::ST_NODE_F;
      end
      mis_mde_pkg::ST_NODE_F: begin
        cmd_o.upd = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.result = 1'b1;
          state_d      = mis_mde_pkg::ST_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = mis_mde_pkg::ST_NODE_A;
        end
      end
      default: begin
        state_d = mis_mde_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/mis_mde_dp.sv
module mis_mde_dp #(
  parameter int unsigned MAX_NODES = mis_mde_pkg::MaxNodesDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mis_mde_pkg::dp_cmd_t     cmd_i,
  output mis_mde_pkg::dp_status_t  status_o,
  input  logic [2:0]              opcode_i,
  input  logic [7:0]              node_a_i,
  input  logic [7:0]              node_b_i,
  input  logic [15:0]             x_value_i,
  input  logic                    cfg_valid_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  output logic                    result_valid_o,
  output logic [15:0]             x_read_o,
  output logic                    set_ok_o,
  output logic [8:0]              set_size_o,
  output logic [8:0]              best_size_o
);

  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned CW   = $clog2(MAX_NODES + 1);
  localparam int unsigned AW   = NW + 16;
  localparam int unsigned GW   = AW + 14;
  localparam int unsigned SUMW = GW + 18;

  // Configuration registers.
  logic [31:0] lr_q;
  logic [15:0] mom_q;
  logic [11:0] gamma_q;
  logic [7:0]  nrew_q;
  logic [8:0]  nc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= mis_mde_pkg::LearningRateReset;
      mom_q   <= mis_mde_pkg::MomentumFactorReset;
      gamma_q <= mis_mde_pkg::EdgePenaltyReset;
      nrew_q  <= mis_mde_pkg::NonedgeRewardReset;
      nc_q    <= mis_mde_pkg::NodeCountReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mis_mde_pkg::REG_LEARNING_RATE:   lr_q    <= cfg_data_i;
        mis_mde_pkg::REG_MOMENTUM_FACTOR: mom_q   <= cfg_data_i[15:0];
        mis_mde_pkg::REG_EDGE_PENALTY:    gamma_q <= cfg_data_i[11:0];
        mis_mde_pkg::REG_NONEDGE_REWARD:  nrew_q  <= cfg_data_i[7:0];
        mis_mde_pkg::REG_NODE_COUNT:      nc_q    <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Effective node count: zero acts as one, large values are capped.
  logic [CW-1:0] n_eff;
  always_comb begin
    if (nc_q == 9'd0) begin
      n_eff = CW'(1);
    end else if (32'(nc_q) > MAX_NODES) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(nc_q);
    end
  end

  // Latched item.
  logic [2:0]  op_q;
  logic [7:0]  a_q, b_q;
  logic [15:0] xv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q <= opcode_i;
      a_q  <= node_a_i;
      b_q  <= node_b_i;
      xv_q <= x_value_i;
    end
  end

  logic          a_ok, b_ok, edge_ok;
  logic [NW-1:0] a_idx, b_idx;
  assign a_ok    = (32'(a_q) < MAX_NODES);
  assign b_ok    = (32'(b_q) < MAX_NODES);
  assign edge_ok = a_ok && b_ok && (a_q != b_q);
  assign a_idx   = NW'(a_q);
  assign b_idx   = NW'(b_q);

  // Node counter.
  logic [NW-1:0] cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + NW'(1);
    end
  end

  assign status_o.cnt_last = ((CW'(cnt_q) + CW'(1)) == n_eff);
  assign status_o.clr_last = (cnt_q == NW'(MAX_NODES - 1));
  assign status_o.is_iter  = (op_q == mis_mde_pkg::OP_ITERATE);

  // Memories.
  logic [MAX_NODES-1:0] row_mem [MAX_NODES];
  logic [15:0]          x_mem   [MAX_NODES];
  logic [47:0]          v_mem   [MAX_NODES];

  logic [MAX_NODES-1:0] row_q, row_wd, bit_a, bit_b;
  logic [NW-1:0]        row_ra, row_wa, x_ra, x_wa;
  logic                 row_we, x_we;
  logic [15:0]          xr_q, x_wd, x_new, xv_sat;
  logic signed [47:0]   vr_q;
  logic [47:0]          v_wd;

  always_comb begin
    bit_a        = '0;
    bit_b        = '0;
    bit_a[a_idx] = 1'b1;
    bit_b[b_idx] = 1'b1;
  end

  assign xv_sat = (xv_q > mis_mde_pkg::XOne) ? mis_mde_pkg::XOne : xv_q;

  assign row_ra = cmd_i.edge_rd_a ? a_idx : (cmd_i.edge_rd_b ? b_idx : cnt_q);
  assign row_wa = cmd_i.edge_wr_a ? a_idx : (cmd_i.edge_wr_b ? b_idx : cnt_q);
  assign row_we = cmd_i.clr || ((cmd_i.edge_wr_a || cmd_i.edge_wr_b) && edge_ok);
  assign row_wd = cmd_i.clr ? '0 : (row_q | (cmd_i.edge_wr_a ? bit_b : bit_a));

  assign x_ra = cmd_i.rdx ? a_idx : cnt_q;
  assign x_wa = cmd_i.wrx ? a_idx : cnt_q;
  assign x_we = cmd_i.clr || (cmd_i.wrx && a_ok) || cmd_i.upd;

  logic signed [47:0] vn_q;
  assign x_wd = cmd_i.upd ? x_new : (cmd_i.wrx ? xv_sat : 16'd0);
  assign v_wd = cmd_i.upd ? vn_q : 48'd0;

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_wa] <= row_wd;
    end
    row_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      x_mem[x_wa] <= x_wd;
    end
    xr_q <= x_mem[x_ra];
  end

  always_ff @(posedge clk_i) begin
    if (x_we) begin
      v_mem[x_wa] <= v_wd;
    end
    vr_q <= v_mem[cnt_q];
  end

  // Scan pipeline flag and index.
  logic          scan_vld_q;
  logic [NW-1:0] idx_pipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_rd;
    end
  end
  always_ff @(posedge clk_i) begin
    idx_pipe_q <= cnt_q;
  end

  // Per-node lanes: neighbour sums, membership and member-neighbour flags.
  logic [AW-1:0]        acc_q [MAX_NODES];
  logic [AW-1:0]        tot_q;
  logic [MAX_NODES-1:0] mvec_q, nbvec_q;
  logic [CW-1:0]        sz_q;
  logic                 member;

  assign member = (xr_q > mis_mde_pkg::XHalf);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        acc_q[j] <= '0;
      end
      tot_q   <= '0;
      mvec_q  <= '0;
      nbvec_q <= '0;
      sz_q    <= '0;
    end else if (scan_vld_q) begin
      for (int j = 0; j < MAX_NODES; j++) begin
        if (row_q[j]) begin
          acc_q[j] <= acc_q[j] + AW'(xr_q);
        end
      end
      tot_q              <= tot_q + AW'(xr_q);
      mvec_q[idx_pipe_q] <= member;
      if (member) begin
        nbvec_q <= nbvec_q | row_q;
        sz_q    <= sz_q + CW'(1);
      end
    end else if (cmd_i.upd) begin
      for (int j = 0; j < MAX_NODES - 1; j++) begin
        acc_q[j] <= acc_q[j + 1];
      end
      acc_q[MAX_NODES-1] <= '0;
    end
  end

  logic [MAX_NODES-1:0] active_mask;
  logic                 set_ok;
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      active_mask[j] = (CW'(j) < n_eff);
    end
  end
  assign set_ok = ~|(~(mvec_q ^ nbvec_q) & active_mask);

  // Per-node momentum step.
  logic [AW+11:0]        p1_q;
  logic [AW+7:0]         p2_q;
  logic signed [64:0]    p3_q;
  logic [15:0]           xj_q;
  logic signed [GW-1:0]  g_q;
  logic signed [48:0]    mv_q;
  logic signed [GW+16:0] q1_q, q2_q;
  logic [AW-1:0]         sc;
  logic [GW-1:0]         g_d;
  logic signed [SUMW-1:0] vsum;
  logic [SUMW-48:0]      vhi;
  logic signed [47:0]    vn_d;
  logic signed [49:0]    t;

  assign sc  = tot_q - acc_q[0] - AW'(xr_q);
  assign g_d = GW'(p1_q) - GW'(p2_q) - GW'(mis_mde_pkg::XOne);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1_q <= gamma_q * acc_q[0];
      p2_q <= nrew_q * sc;
      p3_q <= vr_q * $signed({1'b0, mom_q});
      xj_q <= xr_q;
    end
    if (cmd_i.grad) begin
      g_q  <= $signed(g_d);
      mv_q <= p3_q[64:16];
    end
    if (cmd_i.mul2) begin
      q1_q <= g_q * $signed({1'b0, lr_q[31:16]});
      q2_q <= g_q * $signed({1'b0, lr_q[15:0]});
    end
    if (cmd_i.vel) begin
      vn_q <= vn_d;
    end
  end

  always_comb begin
    vsum = SUMW'(mv_q) + SUMW'(q1_q) + SUMW'($signed(q2_q[GW+16:16]));
    vhi  = vsum[SUMW-1:47];
    if ((&vhi) || !(|vhi)) begin
      vn_d = vsum[47:0];
    end else if (vsum[SUMW-1]) begin
      vn_d = 48'sh8000_0000_0000;
    end else begin
      vn_d = 48'sh7FFF_FFFF_FFFF;
    end
  end

  always_comb begin
    t = $signed({18'd0, xj_q, 16'd0}) - 50'(vn_q) + $signed(50'd32768);
    if (t[49]) begin
      x_new = 16'd0;
    end else if (t[49:16] > 34'd32768) begin
      x_new = mis_mde_pkg::XOne;
    end else begin
      x_new = t[31:16];
    end
  end

  // Result registers.
  logic        res_valid_q;
  logic [15:0] x_read_q;
  logic        set_ok_q;
  logic [8:0]  set_size_q, best_q;
  logic        is_check, is_read;

  assign is_check = (op_q == mis_mde_pkg::OP_CHECK);
  assign is_read  = (op_q == mis_mde_pkg::OP_READ_X);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      best_q      <= '0;
    end else begin
      res_valid_q <= cmd_i.result;
      if (cmd_i.result && is_check && set_ok && (9'(sz_q) > best_q)) begin
        best_q <= 9'(sz_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result) begin
      x_read_q   <= (is_read && a_ok) ? xr_q : 16'd0;
      set_ok_q   <= is_check && set_ok;
      set_size_q <= is_check ? 9'(sz_q) : 9'd0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign x_read_o       = x_read_q;
  assign set_ok_o       = set_ok_q;
  assign set_size_o     = set_size_q;
  assign best_size_o    = best_q;

endmodule

FILE: sv/mis_momentum_descent_engine_core.sv
// Momentum-descent engine for a relaxed maximum independent set. Items enter on a start/busy
// handshake: an item is taken when start is high and busy is low, and busy stays high until the
// item's work is done. Every item produces exactly one result beat, shown for a single cycle with
// result_valid_o high; the receiver cannot stall it, so it must sample the beat in that cycle.
// After reset the block sweeps its three memories (adjacency rows, relaxed x, velocity) one entry
// per cycle and holds busy high until the sweep is done; configuration writes are taken at any time
// (cfg_ready_o is always high) but should only be issued while the block is idle.
// Add edge is a read-modify-write of two adjacency rows through the single row-memory port.
// Iterate and check scan one adjacency row per cycle, accumulating into a lane per node; iterate
// then runs a six-step shared arithmetic sequence per node (gradient products, gradient,
// learning-rate products, saturated velocity, clamped x write-back), which dominates.
module mis_momentum_descent_engine_core #(
  parameter int unsigned MAX_NODES = mis_mde_pkg::MaxNodesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [7:0]  node_a_i,
  input  logic [7:0]  node_b_i,
  input  logic [15:0] x_value_i,
  output logic        result_valid_o,
  output logic [15:0] x_read_o,
  output logic        set_ok_o,
  output logic [8:0]  set_size_o,
  output logic [8:0]  best_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  mis_mde_pkg::dp_cmd_t    cmd;
  mis_mde_pkg::dp_status_t status;

  // Registers can always be written in the cycle they are presented.
  assign cfg_ready_o = 1'b1;

  // The controller sequences every operation; the datapath holds memories, lanes and arithmetic.
  mis_mde_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  mis_mde_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .opcode_i       (opcode_i),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .x_value_i      (x_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .x_read_o       (x_read_o),
    .set_ok_o       (set_ok_o),
    .set_size_o     (set_size_o),
    .best_size_o    (best_size_o)
  );

`ifndef SYNTH
  // A result beat only follows a cycle in which an item was being worked on.
  a_result_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result beat without a preceding busy cycle");

  // An accepted item always keeps the block busy in the following cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The best size never trails a set that passed the check.
  a_best_covers_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && set_ok_o) |-> (best_size_o >= set_size_o))
    else $error("best size below a passing set size");

  // A read x value stays within one.
  a_x_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (x_read_o <= 16'd32768))
    else $error("read x above one");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

// Self-checking bench for the momentum-descent MIS engine.
// A queue of pending items feeds a clocked driver that presents one item at a time on the
// start/busy handshake. A clocked monitor sees every accepted item. It runs the item through a
// shadow copy of the engine (adjacency rows, relaxed x, velocities, best size and the five
// registers) and queues the expected result beat. Every result beat is then compared, field by
// field, with the oldest queued expectation.
module testbench;

  localparam int unsigned NodeSlots = mis_mde_pkg::MaxNodesDefault;
  localparam logic [2:0] OpUnusedLow = 3'd5;
  localparam logic [2:0] OpUnusedHigh = 3'd7;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned ItemsPerPhase = 390;
  localparam longint VelMax = 64'sd140737488355327;
  localparam longint VelMin = -VelMax - 1;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  node_a;
    logic [7:0]  node_b;
    logic [15:0] x_value;
  } engine_item_t;

  typedef struct {
    logic [15:0] x_read;
    logic        set_ok;
    logic [8:0]  set_size;
    logic [8:0]  best_size;
  } engine_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  opcode_i;
  logic [7:0]  node_a_i;
  logic [7:0]  node_b_i;
  logic [15:0] x_value_i;
  logic        result_valid_o;
  logic [15:0] x_read_o;
  logic        set_ok_o;
  logic [8:0]  set_size_o;
  logic [8:0]  best_size_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  mis_momentum_descent_engine_core dut (.*);

  // Shadow copy of the engine state and its registers.
  bit [NodeSlots-1:0] adj_rows [NodeSlots];
  bit [15:0]          x_mem    [NodeSlots];
  longint             vel_mem  [NodeSlots];
  bit [8:0]           best_seen;
  bit [31:0]          lr_reg;
  bit [15:0]          mom_reg;
  bit [11:0]          gamma_reg;
  bit [7:0]           gamma_nb_reg;
  bit [8:0]           count_reg;

  engine_item_t   pending_items [$];
  engine_result_t expected_beats [$];
  int unsigned    items_queued;
  int unsigned    items_sent;
  int unsigned    items_accepted;
  int unsigned    checks_passed;
  int unsigned    iterates_run;
  int unsigned    errors;
  int unsigned    cycle_count;
  int unsigned    idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned nodes_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > NodeSlots) return NodeSlots;
    return count_reg;
  endfunction

  function automatic bit is_member(int unsigned node);
    return x_mem[node] > mis_mde_pkg::XHalf;
  endfunction

  // One momentum step on every node in use, all from the old x values.
  function automatic void momentum_step();
    bit [15:0] old_x [NodeSlots];
    int unsigned n;
    longint sum_nb, sum_other, grad, vel, lr_hi, lr_lo, mom, x_next;
    n = nodes_in_use();
    old_x = x_mem;
    lr_hi = lr_reg[31:16];
    lr_lo = lr_reg[15:0];
    mom = mom_reg;
    for (int unsigned j = 0; j < n; j++) begin
      sum_nb = 0;
      sum_other = 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (i != j) begin
          if (adj_rows[i][j]) sum_nb += old_x[i];
          else sum_other += old_x[i];
        end
      end
      grad = -32768 + longint'(gamma_reg) * sum_nb - longint'(gamma_nb_reg) * sum_other;
      // Arithmetic shifts of signed values round toward minus infinity.
      vel = ((vel_mem[j] * mom) >>> 16) + grad * lr_hi + ((grad * lr_lo) >>> 16);
      if (vel > VelMax) vel = VelMax;
      if (vel < VelMin) vel = VelMin;
      vel_mem[j] = vel;
      x_next = (longint'(old_x[j]) * 65536 - vel + 32768) >>> 16;
      if (x_next < 0) x_next = 0;
      if (x_next > 32768) x_next = 32768;
      x_mem[j] = 16'(x_next);
    end
  endfunction

  // Applies one item to the shadow state and returns the beat it must produce.
  function automatic engine_result_t mis_predict(engine_item_t it);
    engine_result_t res;
    int unsigned n;
    bit has_nb;
    res = '{default: '0};
    n = nodes_in_use();
    case (it.op)
      mis_mde_pkg::OP_ADD_EDGE: begin
        if (it.node_a != it.node_b) begin
          adj_rows[it.node_a][it.node_b] = 1'b1;
          adj_rows[it.node_b][it.node_a] = 1'b1;
        end
      end
      mis_mde_pkg::OP_WRITE_X: begin
        x_mem[it.node_a] = (it.x_value > mis_mde_pkg::XOne) ? mis_mde_pkg::XOne : it.x_value;
        vel_mem[it.node_a] = 0;
      end
      mis_mde_pkg::OP_ITERATE: momentum_step();
      mis_mde_pkg::OP_CHECK: begin
        res.set_ok = 1'b1;
        for (int unsigned j = 0; j < n; j++) begin
          if (is_member(j)) res.set_size++;
          has_nb = 1'b0;
          for (int unsigned i = 0; i < n; i++)
            if (i != j && adj_rows[i][j] && is_member(i)) has_nb = 1'b1;
          // Members need no member neighbor, and every other node needs one.
          if (is_member(j) == has_nb) res.set_ok = 1'b0;
        end
        if (res.set_ok && res.set_size > best_seen) best_seen = res.set_size;
      end
      mis_mde_pkg::OP_READ_X: res.x_read = x_mem[it.node_a];
      default: ;
    endcase
    res.best_size = best_seen;
    return res;
  endfunction

  // Driver: a beat that has been offered stays until the block takes it.
  always @(negedge clk_i) begin
    engine_item_t it;
    if (!rst_ni) begin
      start <= 1'b0;
      opcode_i <= mis_mde_pkg::OP_READ_X;
      node_a_i <= '0;
      node_b_i <= '0;
      x_value_i <= '0;
    end else if (start && items_accepted != items_sent) begin
      start <= 1'b1;
    end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
      it = pending_items.pop_front();
      items_sent++;
      start <= 1'b1;
      opcode_i <= it.op;
      node_a_i <= it.node_a;
      node_b_i <= it.node_b;
      x_value_i <= it.x_value;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: the result beat is checked before the item taken at the same edge is predicted,
  // since that beat always belongs to an earlier item.
  always @(posedge clk_i) begin
    engine_item_t it;
    engine_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: x_read %0d set_ok %0d size %0d best %0d",
                   $time, x_read_o, set_ok_o, set_size_o, best_size_o);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (x_read_o !== want.x_read) begin
            $display("%0t: x_read expected %0d actual %0d", $time, want.x_read, x_read_o);
            errors++;
          end
          if (set_ok_o !== want.set_ok) begin
            $display("%0t: set_ok expected %0d actual %0d", $time, want.set_ok, set_ok_o);
            errors++;
          end
          if (set_size_o !== want.set_size) begin
            $display("%0t: set_size expected %0d actual %0d", $time, want.set_size, set_size_o);
            errors++;
          end
          if (best_size_o !== want.best_size) begin
            $display("%0t: best_size expected %0d actual %0d", $time, want.best_size,
                     best_size_o);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        it = '{op: opcode_i, node_a: node_a_i, node_b: node_b_i, x_value: x_value_i};
        want = mis_predict(it);
        if (it.op == mis_mde_pkg::OP_CHECK && want.set_ok) checks_passed++;
        if (it.op == mis_mde_pkg::OP_ITERATE) iterates_run++;
        expected_beats = {expected_beats, want};
        items_accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  task automatic queue_item(logic [2:0] op, logic [7:0] a, logic [7:0] b, logic [15:0] xv);
    engine_item_t entry;
    entry = '{op: op, node_a: a, node_b: b, x_value: xv};
    pending_items = {pending_items, entry};
    items_queued++;
  endtask

  // Waits until every queued item has been taken and answered and the block is idle.
  task automatic wait_idle();
    while (pending_items.size() > 0 || start || expected_beats.size() > 0 || busy)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(mis_mde_pkg::cfg_reg_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mis_mde_pkg::REG_LEARNING_RATE:   lr_reg = data;
      mis_mde_pkg::REG_MOMENTUM_FACTOR: mom_reg = data[15:0];
      mis_mde_pkg::REG_EDGE_PENALTY:    gamma_reg = data[11:0];
      mis_mde_pkg::REG_NONEDGE_REWARD:  gamma_nb_reg = data[7:0];
      mis_mde_pkg::REG_NODE_COUNT:      count_reg = data[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // New register settings; the extremes of each register come up now and then.
  task automatic reconfigure();
    int unsigned pick;
    wait_idle();
    pick = $urandom_range(9);
    write_reg(mis_mde_pkg::REG_LEARNING_RATE, (pick == 0) ? 32'd0 :
              (pick == 1) ? 32'hFFFF_FFFF :
              (pick == 2) ? $urandom : $urandom_range(32'h1_0000, 32'h40_0000));
    pick = $urandom_range(9);
    write_reg(mis_mde_pkg::REG_MOMENTUM_FACTOR, (pick == 0) ? 32'd0 :
              (pick == 1) ? 32'd65535 : $urandom_range(65535));
    pick = $urandom_range(9);
    write_reg(mis_mde_pkg::REG_EDGE_PENALTY, (pick == 0) ? 32'd0 :
              (pick == 1) ? 32'd4095 : $urandom_range(4095));
    pick = $urandom_range(9);
    write_reg(mis_mde_pkg::REG_NONEDGE_REWARD, (pick == 0) ? 32'd0 :
              (pick == 1) ? 32'd255 : $urandom_range(255));
    // Large node counts make iterate slow, so they stay rare.
    pick = $urandom_range(99);
    write_reg(mis_mde_pkg::REG_NODE_COUNT, (pick < 70) ? $urandom_range(2, 12) :
              (pick < 80) ? 32'd1 : (pick < 84) ? 32'd0 : (pick < 87) ? 32'd256 :
              (pick < 90) ? $urandom_range(257, 511) : $urandom_range(13, 40));
  endtask

  function automatic logic [7:0] any_node(int unsigned n);
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(n - 1));
  endfunction

  // A graph build, a greedy maximal set (or random x), descent steps, checks and reads.
  task automatic run_sequence();
    int unsigned n, steps;
    bit [NodeSlots-1:0] chosen;
    bit blocked;
    n = nodes_in_use();
    repeat ($urandom_range((n > 40) ? 40 : 2 * n)) begin
      if ($urandom_range(15) == 0)
        queue_item(mis_mde_pkg::OP_ADD_EDGE, 8'($urandom), 8'($urandom), 16'($urandom));
      else queue_item(mis_mde_pkg::OP_ADD_EDGE, any_node(n), any_node(n), 16'($urandom));
    end
    wait_idle();
    chosen = '0;
    for (int unsigned j = 0; j < n; j++) begin
      blocked = 1'b0;
      for (int unsigned i = 0; i < j; i++)
        if (chosen[i] && adj_rows[i][j]) blocked = 1'b1;
      chosen[j] = !blocked;
    end
    if ($urandom_range(3) != 0) begin
      for (int unsigned j = 0; j < n; j++) begin
        if ($urandom_range(19) == 0)
          queue_item(mis_mde_pkg::OP_WRITE_X, 8'(j), 8'($urandom), 16'($urandom));
        else if (chosen[j])
          queue_item(mis_mde_pkg::OP_WRITE_X, 8'(j), 8'($urandom),
                     16'($urandom_range(0, 1) ? mis_mde_pkg::XOne :
                         $urandom_range(mis_mde_pkg::XHalf + 1, mis_mde_pkg::XOne)));
        else queue_item(mis_mde_pkg::OP_WRITE_X, 8'(j), 8'($urandom),
                        16'($urandom_range(0, mis_mde_pkg::XHalf)));
      end
      queue_item(mis_mde_pkg::OP_CHECK, 8'($urandom), 8'($urandom), 16'($urandom));
    end
    steps = (n > 40) ? 1 : $urandom_range(0, 5);
    repeat (steps) begin
      queue_item(mis_mde_pkg::OP_ITERATE, 8'($urandom), 8'($urandom), 16'($urandom));
      if ($urandom_range(1))
        queue_item(mis_mde_pkg::OP_CHECK, 8'($urandom), 8'($urandom), 16'($urandom));
    end
    repeat ($urandom_range(1, 3))
      queue_item(mis_mde_pkg::OP_READ_X, any_node(n), 8'($urandom), 16'($urandom));
    // Noise: any opcode, the unused ones too, with fully random fields.
    repeat ($urandom_range(0, 2))
      queue_item(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mis_mde_pkg::REG_LEARNING_RATE;
    cfg_data_i = '0;
    lr_reg = mis_mde_pkg::LearningRateReset;
    mom_reg = mis_mde_pkg::MomentumFactorReset;
    gamma_reg = mis_mde_pkg::EdgePenaltyReset;
    gamma_nb_reg = mis_mde_pkg::NonedgeRewardReset;
    count_reg = mis_mde_pkg::NodeCountReset;
    best_seen = '0;
    foreach (adj_rows[i]) begin
      adj_rows[i] = '0;
      x_mem[i] = '0;
      vel_mem[i] = 0;
    end
    idle_pct = 22;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items at the reset settings: self loop, the edge between the two end nodes,
    // writes above one, exactly one half, unused opcodes and a full-size check and iterate.
    queue_item(mis_mde_pkg::OP_READ_X, 8'd0, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_ADD_EDGE, 8'd5, 8'd5, 16'd0);
    queue_item(mis_mde_pkg::OP_ADD_EDGE, 8'd0, 8'd255, 16'hFFFF);
    queue_item(mis_mde_pkg::OP_WRITE_X, 8'd3, 8'd0, 16'd40000);
    queue_item(mis_mde_pkg::OP_WRITE_X, 8'd255, 8'hFF, 16'hFFFF);
    queue_item(mis_mde_pkg::OP_WRITE_X, 8'd0, 8'd0, mis_mde_pkg::XOne);
    queue_item(mis_mde_pkg::OP_WRITE_X, 8'd1, 8'd0, mis_mde_pkg::XHalf);
    queue_item(mis_mde_pkg::OP_READ_X, 8'd3, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_READ_X, 8'd255, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_READ_X, 8'd1, 8'd0, 16'd0);
    for (logic [3:0] op = 4'(OpUnusedLow); op <= 4'(OpUnusedHigh); op++)
      queue_item(op[2:0], 8'hFF, 8'hFF, 16'hFFFF);
    queue_item(mis_mde_pkg::OP_CHECK, 8'd0, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_ITERATE, 8'd0, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_READ_X, 8'd0, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_READ_X, 8'd3, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_CHECK, 8'd0, 8'd0, 16'd0);
    wait_idle();
    write_reg(mis_mde_pkg::REG_NODE_COUNT, 32'd2);
    queue_item(mis_mde_pkg::OP_WRITE_X, 8'd0, 8'd0, mis_mde_pkg::XOne);
    queue_item(mis_mde_pkg::OP_WRITE_X, 8'd1, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_ADD_EDGE, 8'd1, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_CHECK, 8'd0, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_ITERATE, 8'd0, 8'd0, 16'd0);
    queue_item(mis_mde_pkg::OP_READ_X, 8'd1, 8'd0, 16'd0);

    // Three phases: sender gaps at 22 percent, then 72 percent, then none.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 22 : (phase == 1) ? 72 : 0;
      while (items_queued < (phase + 1) * ItemsPerPhase + 25) begin
        if ($urandom_range(2) == 0) reconfigure();
        run_sequence();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items, %0d descent steps and %0d checks that found a valid set",
             items_accepted, iterates_run, checks_passed);
    $display("across register extremes and node counts from below one to above the maximum.");
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches, %0d beats still expected", errors, expected_beats.size());
      $display("testbench failed");
    end
    $finish;
  end

endmodule
